@@ rtl/iqs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqs_pkg: shared types and constants
// Widths, defaults and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package iqs_pkg;

    localparam int unsigned MaxSamplesDefault = 1024;
    localparam int unsigned SampleWidth = 32;
    localparam int unsigned FracWidth = 17;
    localparam logic [FracWidth-1:0] FracReset = 17'd32768;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;      // empty the store after a result
        logic shift_step; // move one entry up and compare the next one down
        logic write_new;  // write the new sample at the found slot
        logic rd_lo;      // read the lower interpolation entry
        logic rd_hi;      // read the upper interpolation entry
        logic calc;       // form the interpolated result
        logic load_out;   // latch the result
    } iqs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;        // store holds the capacity
        logic slot_found;  // insertion slot reached
        logic need_hi;     // interpolation needs the upper entry
        logic calc_done;   // result ready
    } iqs_stat_t;

endpackage : iqs_pkg
`default_nettype wire

@@ rtl/iqs_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqs_stream_if: valid/ready channel
// Carries one payload of width W with a source and a sink modport.
// ----------------------------------------------------------------------------
interface iqs_stream_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : iqs_stream_if
`default_nettype wire

@@ rtl/iqs_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqs_datapath: sorted sample store and interpolation arithmetic
// Holds the sorted memory, the insertion pointer and the result registers.
// ----------------------------------------------------------------------------
module iqs_datapath #(
    parameter int unsigned MAX_SAMPLES = iqs_pkg::MaxSamplesDefault
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire iqs_pkg::iqs_cmd_t               cmd,
    output iqs_pkg::iqs_stat_t                   stat,
    input  wire logic signed [31:0]              new_value,
    input  wire logic                            new_load,
    input  wire logic [iqs_pkg::FracWidth-1:0]   fractile,
    output logic signed [31:0]                   quantile_value,
    output logic                                 empty_error,
    output logic                                 overflow_flag
);
    localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned PW = CW + iqs_pkg::FracWidth;

    logic signed [31:0] mem [MAX_SAMPLES];
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic signed [31:0] val_reg;
    logic signed [31:0] rd_reg;
    logic          rd_ok_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic [15:0]   r_reg;
    logic [AW-1:0] idx_reg;
    logic          hi_sel_reg;
    logic [1:0]    phase_reg;
    logic signed [49:0] prod_reg;

    // Product of fractile and count, and derived position.
    logic [PW-1:0] p_full;
    logic [PW-1:0] t_full;
    logic          p_low, p_high;
    assign p_full = PW'(fractile) * PW'(count_reg);
    assign t_full = p_full - PW'(17'h10000);
    assign p_low  = p_full < PW'(17'h10000);
    assign p_high = p_full > (PW'(count_reg - CW'(1)) << 16);

    // Read address for the insertion scan and interpolation.
    logic [AW-1:0] rd_addr;
    always_comb
    begin
        rd_addr = ptr_reg[AW-1:0] - AW'(1);
        if (cmd.rd_lo || cmd.rd_hi) rd_addr = idx_reg;
    end

    assign stat.full       = (count_reg == CW'(MAX_SAMPLES));
    assign stat.slot_found = (ptr_reg == '0) || (rd_ok_reg && (rd_reg <= val_reg));
    assign stat.need_hi    = hi_sel_reg;
    assign stat.calc_done  = (phase_reg == 2'd2);

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.write_new)
            mem[ptr_reg[AW-1:0]] <= val_reg;
        else if (cmd.shift_step && !stat.slot_found)
            mem[ptr_reg[AW-1:0]] <= rd_reg;
        rd_reg <= mem[rd_addr];
    end

    // Insertion pointer and new-sample capture.
    always_comb
    begin
        ptr_next   = ptr_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        if (new_load)
        begin
            ptr_next = count_reg;
            if (stat.full) drop_next = 1'b1;
        end
        else if (cmd.shift_step && !stat.slot_found)
        begin
            ptr_next = ptr_reg - CW'(1);
        end
        if (cmd.write_new) count_next = count_reg + CW'(1);
        if (cmd.clear)
        begin
            count_next = '0;
            drop_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
            ptr_reg   <= '0;
            rd_ok_reg <= 1'b0;
            phase_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
            ptr_reg   <= ptr_next;
            // The read data is marked invalid after a scan step moves the address or a new sample loads.
            rd_ok_reg <= cmd.shift_step && !stat.slot_found ? 1'b0 : !new_load;
            if (cmd.calc && phase_reg != 2'd2) phase_reg <= phase_reg + 2'd1;
            else if (!cmd.calc) phase_reg <= 2'd0;
        end
    end

    // Position decode when the set closes.
    always_ff @(posedge clk)
    begin
        if (new_load) val_reg <= new_value;
        if (!cmd.rd_lo && !cmd.rd_hi && !cmd.calc)
        begin
            if (p_low)
            begin
                idx_reg <= '0; r_reg <= '0;
            end
            else if (p_high)
            begin
                idx_reg <= AW'(count_reg - CW'(1)); r_reg <= '0;
            end
            else
            begin
                idx_reg <= AW'(t_full >> 16); r_reg <= t_full[15:0];
            end
            hi_sel_reg <= !p_low && !p_high && (t_full[15:0] != 16'd0);
        end
        if (cmd.rd_lo && !cmd.rd_hi) idx_reg <= idx_reg + AW'(1);
        if (cmd.rd_hi) lo_reg <= rd_reg;
        if (cmd.calc && phase_reg == 2'd0)
        begin
            if (!hi_sel_reg) lo_reg <= rd_reg;
            hi_reg <= rd_reg;
        end
        if (cmd.calc && phase_reg == 2'd1)
            prod_reg <= 50'($signed({1'b0, r_reg})) * (50'(hi_reg) - 50'(lo_reg));
    end

    // Output registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            empty_error   <= (count_reg == '0);
            overflow_flag <= drop_reg;
            if (count_reg == '0)
                quantile_value <= '0;
            else if (hi_sel_reg)
                quantile_value <= 32'(50'(lo_reg) + (prod_reg >>> 16));
            else
                quantile_value <= lo_reg;
        end
    end
endmodule : iqs_datapath
`default_nettype wire

@@ rtl/iqs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqs_ctrl: sequencer for insertion and result computation
// Steps the datapath through the insert scan and the interpolation reads.
// ----------------------------------------------------------------------------
module iqs_ctrl (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire logic                   in_fire,
    input  wire logic                   in_last,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output iqs_pkg::iqs_cmd_t           cmd,
    input  wire iqs_pkg::iqs_stat_t     stat
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_POS  = 3'd2;
    localparam logic [2:0] S_LO   = 3'd3;
    localparam logic [2:0] S_HI   = 3'd4;
    localparam logic [2:0] S_CALC = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       last_reg, full_reg;
    logic       wait_reg;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next-state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire) state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (full_reg)
                    state_next = last_reg ? S_POS : S_IDLE;
                else if (!wait_reg)
                begin
                    cmd.shift_step = 1'b1;
                    if (stat.slot_found)
                    begin
                        cmd.write_new = 1'b1;
                        state_next = last_reg ? S_POS : S_IDLE;
                    end
                end
            end
            S_POS: state_next = S_LO;
            S_LO:
            begin
                cmd.rd_lo = 1'b1;
                state_next = stat.need_hi ? S_HI : S_CALC;
            end
            S_HI:
            begin
                cmd.rd_hi = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.calc = 1'b1;
                if (stat.calc_done) state_next = S_OUT;
            end
            S_OUT:
            begin
                // Wait here while the previous result is still pending.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    cmd.clear      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            full_reg      <= 1'b0;
            wait_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                last_reg <= in_last;
                full_reg <= stat.full;
            end
            // After each step or new sample the scan waits while the read data settles.
            wait_reg <= in_fire || (cmd.shift_step && !stat.slot_found);
        end
    end
endmodule : iqs_ctrl
`default_nettype wire

@@ rtl/interpolated_quantile_select.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// interpolated_quantile_select: interpolated quantile of a streamed set
// Sorts samples on arrival and returns the interpolated fractile value.
// ----------------------------------------------------------------------------
// Each sample is insertion-sorted into a memory with one write and one
// registered read per cycle by walking down from the top entry, moving one
// entry per scan step. The next sample is taken only once the last one is
// stored, which takes longer the more stored entries are larger than it, or
// dropped from a full store. A set-closing sample then passes through the
// position decode, the lower read, the upper read when it is needed, the
// three-step multiply and the output load. A result waits in the output
// register while the next set streams in; only the next result stalls until
// it is taken. The store needs no clearing after reset; the count alone
// marks it.
module interpolated_quantile_select #(
    parameter int unsigned MAX_SAMPLES = iqs_pkg::MaxSamplesDefault
) (
    input  wire   clk,
    input  wire   rst_n,
    iqs_stream_if.sink   cfg,
    iqs_stream_if.sink   in_ch,
    iqs_stream_if.source out_ch
);
    logic [iqs_pkg::FracWidth-1:0] fractile_reg;
    iqs_pkg::iqs_cmd_t  cmd;
    iqs_pkg::iqs_stat_t stat;
    logic in_ready;
    logic in_fire;
    logic signed [31:0] q_val;
    logic q_empty, q_ovf;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = in_ready;
    assign in_fire     = in_ch.valid && in_ready;
    assign out_ch.data = {q_val, q_empty, q_ovf};

    // Fractile register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fractile_reg <= iqs_pkg::FracReset;
        else if (cfg.valid) fractile_reg <= cfg.data[iqs_pkg::FracWidth-1:0];
    end

    iqs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_ch.data[0]),
        .in_ready(in_ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .stat(stat)
    );

    iqs_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .new_value(in_ch.data[32:1]), .new_load(in_fire), .fractile(fractile_reg),
        .quantile_value(q_val), .empty_error(q_empty), .overflow_flag(q_ovf)
    );

    // A waiting result stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed while waiting");
    // A store write never coincides with a result load.
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_out && cmd.write_new)) else $error("command overlap");
    // The clear command comes only with a result.
    a_clear_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> out_ch.valid) else $error("clear without result");
endmodule : interpolated_quantile_select
`default_nettype wire
